### hw/rtl/echo_range_counter_display_macros.svh
// Assertion macros shared by the echo ranging counter RTL.
`ifndef ECHO_RANGE_COUNTER_DISPLAY_MACROS_SVH
`define ECHO_RANGE_COUNTER_DISPLAY_MACROS_SVH

// Implication in the same cycle, checked on clk and quiet while in reset.
`define ERC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("erc assertion failed");

// Implication checked in the cycle after the antecedent.
`define ERC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("erc assertion failed");

`endif

### hw/rtl/erc_pkg.sv
// Shared types, constants and helper functions of the echo ranging counter.
package erc_pkg;

    // Width of the echo tick counter.
    localparam int COUNT_WIDTH = 14;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Distance and configuration register widths.
    localparam int DIST_WIDTH = 14;
    localparam int CFG_WIDTH = 14;
    localparam logic [DIST_WIDTH-1:0] DIST_MAX = 14'd9999;
    localparam logic [CFG_WIDTH-1:0] TIMEOUT_RESET = 14'd300;
    localparam logic [CFG_WIDTH-1:0] THRESHOLD_RESET = 14'd15;

    // Configuration register indexes.
    localparam logic REG_TIMEOUT_LIMIT = 1'b0;
    localparam logic REG_OPEN_THRESHOLD = 1'b1;

    // Display geometry.
    localparam int BCD_DIGITS = 4;
    localparam int DIGIT_IDX_WIDTH = $clog2(BCD_DIGITS);
    localparam int SEG_WIDTH = 7;

    typedef logic [BCD_DIGITS-1:0][3:0] bcd_t;
    localparam bcd_t BCD_MAX = {4'd9, 4'd9, 4'd9, 4'd9};

    // Measurement status handed from the counter to the display and result path.
    typedef struct packed {
        bcd_t                  held_bcd;
        logic [DIST_WIDTH-1:0] distance;
        logic                  finished;
        logic                  lid_open;
    } meas_t;

    // One result word.
    typedef struct packed {
        logic [BCD_DIGITS-1:0] digit_enable;
        logic [SEG_WIDTH-1:0]  segments;
        logic [DIST_WIDTH-1:0] distance;
        logic                  measure_done;
        logic                  lid_open;
        logic                  bin_full;
    } result_t;

    // Add one to a decimal count, ones digit first.
    function automatic bcd_t bcd_inc(input bcd_t v);
        bcd_t r;
        logic carry;
        r = v;
        carry = 1'b1;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (carry)
            begin
                if (v[i] == 4'd9)
                begin
                    r[i] = 4'd0;
                end
                else
                begin
                    r[i] = v[i] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        return r;
    endfunction

    // Seven-segment pattern of a decimal digit; blank for codes above nine.
    function automatic logic [SEG_WIDTH-1:0] seg_pattern(input logic [3:0] d);
        logic [SEG_WIDTH-1:0] p;
        unique case (d)
            4'd0:    p = 7'h3f;
            4'd1:    p = 7'h06;
            4'd2:    p = 7'h5b;
            4'd3:    p = 7'h4f;
            4'd4:    p = 7'h66;
            4'd5:    p = 7'h6d;
            4'd6:    p = 7'h7d;
            4'd7:    p = 7'h07;
            4'd8:    p = 7'h7f;
            4'd9:    p = 7'h6f;
            default: p = 7'h00;
        endcase
        return p;
    endfunction

    // Digit strobe: ones on the top bit down to thousands on the bottom bit.
    function automatic logic [BCD_DIGITS-1:0] digit_select(
        input logic [DIGIT_IDX_WIDTH-1:0] idx
    );
        logic [BCD_DIGITS-1:0] s;
        s = '0;
        s[BCD_DIGITS-1-int'(idx)] = 1'b1;
        return s;
    endfunction

endpackage

### hw/rtl/echo_range_counter_display.sv
// Top level of the echo ranging counter with four-digit seven-segment display.
// Result words are registered in a two-entry buffer and offered from there in order.
// Throughput: one word per cycle while the buffer has space; the counter, edge detector
// and display index update in the accepting cycle, and the buffer absorbs output stalls.
// Reset: asynchronous, active low; measurement idle, counts and distance zero.
module echo_range_counter_display (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_index,
    input  logic [erc_pkg::CFG_WIDTH-1:0]       cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                start_req,
    input  logic                                echo_level,
    input  logic                                count_tick,
    input  logic                                scan_tick,
    input  logic                                fill_sense,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [erc_pkg::BCD_DIGITS-1:0]      digit_enable,
    output logic [erc_pkg::SEG_WIDTH-1:0]       segments,
    output logic [erc_pkg::DIST_WIDTH-1:0]      distance,
    output logic                                measure_done,
    output logic                                lid_open,
    output logic                                bin_full
);

    logic                                   accept;
    erc_pkg::meas_t                         status;
    logic [erc_pkg::BCD_DIGITS-1:0]         dig_en;
    logic [erc_pkg::SEG_WIDTH-1:0]          seg;
    erc_pkg::result_t                       push_word, out_word;

    assign accept = in_valid && in_ready;

    erc_measure u_measure (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .start_req  (start_req),
        .echo_level (echo_level),
        .count_tick (count_tick),
        .status     (status)
    );

    erc_display u_display (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .scan_tick    (scan_tick),
        .held_bcd     (status.held_bcd),
        .digit_enable (dig_en),
        .segments     (seg)
    );

    // Assemble the result word of this input word.
    always_comb
    begin
        push_word.digit_enable = dig_en;
        push_word.segments     = seg;
        push_word.distance     = status.distance;
        push_word.measure_done = status.finished;
        push_word.lid_open     = status.lid_open;
        push_word.bin_full     = !fill_sense;
    end

    erc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_word (push_word),
        .has_space (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    // Result ports.
    assign digit_enable = out_word.digit_enable;
    assign segments     = out_word.segments;
    assign distance     = out_word.distance;
    assign measure_done = out_word.measure_done;
    assign lid_open     = out_word.lid_open;
    assign bin_full     = out_word.bin_full;

    // Checks on the result path.
`include "echo_range_counter_display_macros.svh"
    `ERC_ASSERT_NOW(a_digit_onehot, out_valid, $onehot(digit_enable))
    `ERC_ASSERT_NOW(a_lid_needs_done, out_valid && lid_open, measure_done)
    `ERC_ASSERT_NOW(a_stall_only_full, !in_ready, out_valid)
    `ERC_ASSERT_NEXT(a_full_after_stall, !in_ready && !out_ready, !in_ready && out_valid)

endmodule

### hw/rtl/erc_measure.sv
// Echo measurement: configuration registers, edge detection, counting and latch.
module erc_measure (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_index,
    input  logic [erc_pkg::CFG_WIDTH-1:0]  cfg_data,
    input  logic                           accept,
    input  logic                           start_req,
    input  logic                           echo_level,
    input  logic                           count_tick,
    output erc_pkg::meas_t                 status
);

    typedef enum logic [2:0] {
        PH_WAIT  = 3'b001,
        PH_COUNT = 3'b010,
        PH_DONE  = 3'b100
    } phase_t;

    phase_t                             phase_reg, phase_next;
    logic [erc_pkg::COUNT_WIDTH-1:0]    count_reg, count_next, count_inc;
    erc_pkg::bcd_t                      bcd_cnt_reg, bcd_cnt_next, bcd_cnt_inc;
    erc_pkg::bcd_t                      held_bcd_reg, held_bcd_next;
    logic [erc_pkg::DIST_WIDTH-1:0]     held_dist_reg, held_dist_next;
    logic                               echo_prev_reg;
    logic [erc_pkg::CFG_WIDTH-1:0]      timeout_reg, threshold_reg;
    logic                               rise, fall, finished, not_top;

    // Configuration writes are taken whenever the enable is high.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= erc_pkg::TIMEOUT_RESET;
            threshold_reg <= erc_pkg::THRESHOLD_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                erc_pkg::REG_TIMEOUT_LIMIT:  timeout_reg   <= cfg_data;
                erc_pkg::REG_OPEN_THRESHOLD: threshold_reg <= cfg_data;
                default:                     timeout_reg   <= timeout_reg;
            endcase
        end
    end

    // Next state of the measurement for the word on the input.
    always_comb
    begin
        rise        = echo_level && !echo_prev_reg;
        fall        = !echo_level && echo_prev_reg;
        not_top     = (count_reg != erc_pkg::COUNT_MAX);
        count_inc   = not_top ? count_reg + erc_pkg::COUNT_WIDTH'(1) : count_reg;
        // The decimal copy tracks the count clamped to four digits.
        bcd_cnt_inc = (not_top && (bcd_cnt_reg != erc_pkg::BCD_MAX))
                      ? erc_pkg::bcd_inc(bcd_cnt_reg) : bcd_cnt_reg;
        phase_next   = phase_reg;
        count_next   = count_reg;
        bcd_cnt_next = bcd_cnt_reg;
        finished     = 1'b0;
        if (start_req)
        begin
            phase_next   = PH_WAIT;
            count_next   = '0;
            bcd_cnt_next = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_WAIT:
                begin
                    if (rise)
                    begin
                        phase_next = PH_COUNT;
                    end
                end
                PH_COUNT:
                begin
                    if (fall)
                    begin
                        finished = 1'b1;
                    end
                    else if (count_tick)
                    begin
                        count_next   = count_inc;
                        bcd_cnt_next = bcd_cnt_inc;
                        if (32'(count_inc) > 32'(timeout_reg))
                        begin
                            finished = 1'b1;
                        end
                    end
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end
        if (finished)
        begin
            phase_next = PH_DONE;
        end
    end

    // Latch of the distance when a measurement ends, clamped to four digits.
    always_comb
    begin
        held_dist_next = held_dist_reg;
        held_bcd_next  = held_bcd_reg;
        if (finished)
        begin
            held_bcd_next = bcd_cnt_next;
            if (32'(count_next) > 32'(erc_pkg::DIST_MAX))
            begin
                held_dist_next = erc_pkg::DIST_MAX;
            end
            else
            begin
                held_dist_next = erc_pkg::DIST_WIDTH'(count_next);
            end
        end
    end

    // State advances once for every accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_DONE;
            count_reg     <= '0;
            bcd_cnt_reg   <= '0;
            held_bcd_reg  <= '0;
            held_dist_reg <= '0;
            echo_prev_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            bcd_cnt_reg   <= bcd_cnt_next;
            held_bcd_reg  <= held_bcd_next;
            held_dist_reg <= held_dist_next;
            echo_prev_reg <= echo_level;
        end
    end

    // Status after this word.
    always_comb
    begin
        status.held_bcd = held_bcd_next;
        status.distance = held_dist_next;
        status.finished = finished;
        status.lid_open = finished && (held_dist_next <= threshold_reg);
    end

endmodule

### hw/rtl/erc_display.sv
// Four-digit multiplexed display: digit scan index, strobe and segment decode.
module erc_display (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic                                scan_tick,
    input  erc_pkg::bcd_t                       held_bcd,
    output logic [erc_pkg::BCD_DIGITS-1:0]      digit_enable,
    output logic [erc_pkg::SEG_WIDTH-1:0]       segments
);

    logic [erc_pkg::DIGIT_IDX_WIDTH-1:0] digit_idx_reg;

    // The scan tick moves to the next digit after the current word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_idx_reg <= '0;
        end
        else if (accept && scan_tick)
        begin
            digit_idx_reg <= digit_idx_reg + erc_pkg::DIGIT_IDX_WIDTH'(1);
        end
    end

    // Strobe and pattern of the digit currently selected.
    assign digit_enable = erc_pkg::digit_select(digit_idx_reg);
    assign segments     = erc_pkg::seg_pattern(held_bcd[digit_idx_reg]);

endmodule

### hw/rtl/erc_out_buf.sv
// Two-entry result buffer that decouples the input side from output stalls.
module erc_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  erc_pkg::result_t push_word,
    output logic             has_space,
    output logic             out_valid,
    input  logic             out_ready,
    output erc_pkg::result_t out_word
);

    erc_pkg::result_t entry_reg [2];
    logic [1:0]       count_reg, count_next;
    logic             wr_ptr_reg, rd_ptr_reg;
    logic             pop;

    assign out_valid = (count_reg != 2'd0);
    assign has_space = (count_reg != 2'd2);
    assign out_word  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

### dv/tb.sv
// Self-checking testbench for the echo ranging counter with seven-segment display.
`timescale 1ns / 100ps

module tb;

    // Measurement phases as the counter walks through them.
    typedef enum logic [2:0] {
        MEAS_WAIT  = 3'b001,
        MEAS_COUNT = 3'b010,
        MEAS_IDLE  = 3'b100
    } meas_phase_t;

    // One row of the directed table: the input word, and a fixed expectation where one is given.
    typedef struct packed {
        logic             start;
        logic             echo;
        logic             tick;
        logic             scan;
        logic             fill;
        logic             fixed;
        erc_pkg::result_t word;
    } stim_row_t;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 60;
    localparam int RANDOM_WORDS = 1350;
    localparam int PHASES       = 10;
    localparam int ROWS         = 23;

    // Segment patterns of the decimal digits, zero at index 0.
    localparam logic [9:0][erc_pkg::SEG_WIDTH-1:0] SEG_CODES = {
        7'h6f, 7'h7f, 7'h07, 7'h7d, 7'h6d, 7'h66, 7'h4f, 7'h5b, 7'h06, 7'h3f
    };

    logic                                  clk;
    logic                                  rst_n;
    logic                                  cfg_wr_en;
    logic                                  cfg_index;
    logic [erc_pkg::CFG_WIDTH-1:0]         cfg_data;
    logic                                  in_valid;
    logic                                  in_ready;
    logic                                  start_req;
    logic                                  echo_level;
    logic                                  count_tick;
    logic                                  scan_tick;
    logic                                  fill_sense;
    logic                                  out_valid;
    logic                                  out_ready;
    logic [erc_pkg::BCD_DIGITS-1:0]        digit_enable;
    logic [erc_pkg::SEG_WIDTH-1:0]         segments;
    logic [erc_pkg::DIST_WIDTH-1:0]        distance;
    logic                                  measure_done;
    logic                                  lid_open;
    logic                                  bin_full;

    // Fixed expectation travelling with the word on offer.
    logic                                  row_fixed;
    erc_pkg::result_t                      row_word;

    // Predicted state of the counter and its display.
    meas_phase_t                           meas_phase = MEAS_IDLE;
    logic [erc_pkg::COUNT_WIDTH-1:0]       tick_count = '0;
    logic [erc_pkg::DIST_WIDTH-1:0]        held_dist = '0;
    logic [erc_pkg::DIGIT_IDX_WIDTH-1:0]   scan_pos = '0;
    logic                                  echo_seen = 1'b0;
    logic [erc_pkg::CFG_WIDTH-1:0]         limit_cfg = erc_pkg::TIMEOUT_RESET;
    logic [erc_pkg::CFG_WIDTH-1:0]         thresh_cfg = erc_pkg::THRESHOLD_RESET;

    erc_pkg::result_t                      due_words[$];
    erc_pkg::result_t                      predicted;
    erc_pkg::result_t                      seen_word;
    erc_pkg::result_t                      want_word;
    int                                    fail_count = 0;
    int                                    words_sent = 0;
    int                                    cycle_count = 0;
    bit                                    no_gaps = 1'b0;
    bit                                    hold_off_req = 1'b0;

    stim_row_t directed_rows [ROWS] = '{
        // Display scan straight after reset, with idle ticks and edges ignored.
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, '{4'h8, 7'h3f, 14'd0, 1'b0, 1'b0, 1'b0}},
        '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, '{4'h8, 7'h3f, 14'd0, 1'b0, 1'b0, 1'b1}},
        '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, '{4'h4, 7'h3f, 14'd0, 1'b0, 1'b0, 1'b0}},
        '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, '{4'h2, 7'h3f, 14'd0, 1'b0, 1'b0, 1'b1}},
        '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, '{4'h1, 7'h3f, 14'd0, 1'b0, 1'b0, 1'b0}},
        // Start with a rising echo and a tick in the same word: neither is acted on.
        '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, '0},
        '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, '0},
        '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, '0},
        // Rise, three ticks, then a fall that carries a tick.
        '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, '0},
        '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, '0},
        '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, '0},
        '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, '0},
        '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, '0},
        // Restart in the middle of a count.
        '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, '0},
        '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, '0},
        '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, '0},
        '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, '0},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, '0},
        '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, '0},
        '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, '0},
        '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, '0}
    };

    echo_range_counter_display dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .start_req    (start_req),
        .echo_level   (echo_level),
        .count_tick   (count_tick),
        .scan_tick    (scan_tick),
        .fill_sense   (fill_sense),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .digit_enable (digit_enable),
        .segments     (segments),
        .distance     (distance),
        .measure_done (measure_done),
        .lid_open     (lid_open),
        .bin_full     (bin_full)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Advance the predicted counter by one sample and return the display word it gives.
    function automatic erc_pkg::result_t next_display_word(input logic s, input logic e,
                                                           input logic t, input logic c,
                                                           input logic f);
        erc_pkg::result_t r;
        logic             done;
        int               v;
        done = 1'b0;
        if (s)
        begin
            meas_phase = MEAS_WAIT;
            tick_count = '0;
        end
        else if (meas_phase == MEAS_WAIT)
        begin
            if (e && !echo_seen)
                meas_phase = MEAS_COUNT;
        end
        else if (meas_phase == MEAS_COUNT)
        begin
            if (!e && echo_seen)
                done = 1'b1;
            else if (t)
            begin
                if (tick_count != erc_pkg::COUNT_MAX)
                    tick_count = tick_count + 1'b1;
                if (tick_count > limit_cfg)
                    done = 1'b1;
            end
        end
        echo_seen = e;
        if (done)
        begin
            meas_phase = MEAS_IDLE;
            held_dist = (tick_count > erc_pkg::DIST_MAX) ? erc_pkg::DIST_MAX : tick_count;
        end
        // The digit shown is picked before this sample's scan advance.
        v = int'(held_dist);
        for (int k = 0; k < int'(scan_pos); k++)
            v = v / 10;
        r.digit_enable = 4'b1000 >> scan_pos;
        r.segments     = SEG_CODES[v % 10];
        r.distance     = held_dist;
        r.measure_done = done;
        r.lid_open     = done && (held_dist <= thresh_cfg);
        r.bin_full     = !f;
        if (c)
            scan_pos = scan_pos + 1'b1;
        return r;
    endfunction

    function automatic bit coin(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Offer one sample word after a random gap and hold it until it is taken.
    task automatic drive_word(input logic s, input logic e, input logic t, input logic c,
                              input logic f, input logic fixed = 1'b0,
                              input erc_pkg::result_t word = '0);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        start_req  <= s;
        echo_level <= e;
        count_tick <= t;
        scan_tick  <= c;
        fill_sense <= f;
        row_fixed  <= fixed;
        row_word   <= word;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
    endtask

    // Write one register and keep the predictor's copy in step.
    task automatic write_reg(input logic idx, input logic [erc_pkg::CFG_WIDTH-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == erc_pkg::REG_TIMEOUT_LIMIT)
            limit_cfg = val;
        else
            thresh_cfg = val;
        @(posedge clk);
    endtask

    // Stop offering and wait until every predicted word has come out.
    task automatic settle_outputs();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        // Let the predictor record the last accepted word before the queue is checked.
        @(posedge clk);
        while (due_words.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    // A well-formed measurement: start, low echo, a high pulse with ticks, then the fall.
    task automatic run_echo_pulse(input int lim);
        int hi_len;
        int tick_pct;
        if (lim <= 400 && (coin(3) || (lim <= 64 && coin(20))))
        begin
            hi_len = lim + $urandom_range(0, 3);
            tick_pct = 100;
        end
        else
        begin
            hi_len = $urandom_range(0, 24);
            tick_pct = 70;
        end
        drive_word(1'b1, coin(50), coin(50), coin(30), coin(80));
        repeat ($urandom_range(1, 3))
            drive_word(1'b0, 1'b0, coin(50), coin(30), coin(80));
        repeat (hi_len)
            drive_word(1'b0, 1'b1, coin(tick_pct), coin(30), coin(80));
        drive_word(1'b0, 1'b0, coin(50), coin(30), coin(80));
    endtask

    // Stimulus and the final verdict.
    initial
    begin
        int                            phase_end;
        logic [erc_pkg::CFG_WIDTH-1:0] lim;
        logic [erc_pkg::CFG_WIDTH-1:0] thr;
        rst_n      = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = erc_pkg::REG_TIMEOUT_LIMIT;
        cfg_data   = '0;
        in_valid   = 1'b0;
        start_req  = 1'b0;
        echo_level = 1'b0;
        count_tick = 1'b0;
        scan_tick  = 1'b0;
        fill_sense = 1'b1;
        row_fixed  = 1'b0;
        row_word   = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            drive_word(directed_rows[i].start, directed_rows[i].echo, directed_rows[i].tick,
                       directed_rows[i].scan, directed_rows[i].fill, directed_rows[i].fixed,
                       directed_rows[i].word);

        for (int phase_no = 0; phase_no < PHASES; phase_no++)
        begin
            settle_outputs();
            case (phase_no)
                0:
                begin
                    lim = erc_pkg::TIMEOUT_RESET;
                    thr = erc_pkg::THRESHOLD_RESET;
                end
                1:
                begin
                    lim = 14'd1;
                    thr = 14'd0;
                end
                2:
                begin
                    lim = 14'd9998;
                    thr = 14'd9999;
                end
                3:
                begin
                    lim = '1;
                    thr = 14'($urandom_range(0, 9999));
                end
                9:
                begin
                    lim = 14'd2;
                    thr = 14'd9999;
                end
                default:
                begin
                    lim = 14'($urandom_range(1, 64));
                    thr = 14'($urandom_range(0, 70));
                end
            endcase
            write_reg(erc_pkg::REG_TIMEOUT_LIMIT, lim);
            write_reg(erc_pkg::REG_OPEN_THRESHOLD, thr);
            no_gaps = (phase_no == 5);
            // Long receiver hold-off while the sender keeps offering words.
            if (phase_no == 4)
                hold_off_req = 1'b1;
            phase_end = words_sent + RANDOM_WORDS / PHASES;
            while (words_sent < phase_end)
            begin
                if (coin(80))
                    run_echo_pulse(int'(lim));
                else
                    repeat ($urandom_range(1, 8))
                        drive_word(coin(10), coin(50), coin(50), coin(50), coin(50));
            end
        end

        settle_outputs();
        if (due_words.size() != 0)
        begin
            fail_count += due_words.size();
            $display("%0d expected display words never arrived", due_words.size());
        end
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Receiver: a random hold-off before each word, and one long stall on request.
    initial
    begin
        int gap;
        out_ready = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            gap = no_gaps ? 0 : $urandom_range(0, 4);
            if (hold_off_req)
            begin
                gap = HOLD_CYCLES;
                hold_off_req = 1'b0;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Predict the display word of every accepted sample word.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            predicted = next_display_word(start_req, echo_level, count_tick, scan_tick,
                                          fill_sense);
            due_words.push_back(row_fixed ? row_word : predicted);
        end
    end

    // Compare every accepted display word with the oldest one predicted.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_word.digit_enable = digit_enable;
            seen_word.segments     = segments;
            seen_word.distance     = distance;
            seen_word.measure_done = measure_done;
            seen_word.lid_open     = lid_open;
            seen_word.bin_full     = bin_full;
            if (due_words.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("display word with none expected: en=%h seg=%h dist=%0d",
                             digit_enable, segments, distance);
            end
            else
            begin
                want_word = due_words.pop_front();
                if (want_word.digit_enable !== seen_word.digit_enable
                    || want_word.segments !== seen_word.segments
                    || want_word.distance !== seen_word.distance
                    || want_word.measure_done !== seen_word.measure_done
                    || want_word.lid_open !== seen_word.lid_open
                    || want_word.bin_full !== seen_word.bin_full)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"display word mismatch: expected en=%h seg=%h dist=%0d ",
                                  "done=%b lid=%b full=%b, got en=%h seg=%h dist=%0d ",
                                  "done=%b lid=%b full=%b"},
                                 want_word.digit_enable, want_word.segments,
                                 want_word.distance, want_word.measure_done,
                                 want_word.lid_open, want_word.bin_full,
                                 seen_word.digit_enable, seen_word.segments,
                                 seen_word.distance, seen_word.measure_done,
                                 seen_word.lid_open, seen_word.bin_full);
                end
            end
        end
    end

    // Watchdog on the length of the run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule
